/* design/pfs_pkg.sv */
// Shared types, constants and widths for the pulsed frequency sensor sequencer.
package pfs_pkg;

  // Capture limit per window and the widths that follow from it.
  localparam int MAX_CAPTURES = 256;

  localparam int FUNC_W     = 2;
  localparam int PERIOD_W   = 16;
  localparam int TICK_W     = 16;
  localparam int WCOUNT_W   = 8;
  localparam int ACC_W      = 16;
  localparam int POINT_W    = 8;
  localparam int READING_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int CAP_W       = $clog2(MAX_CAPTURES + 1);
  localparam int SUM_W       = PERIOD_W + $clog2(MAX_CAPTURES);
  localparam int POINT_SCALE = 40000;
  localparam int POINT_BIAS  = 75;
  localparam int NUM_W       = $clog2(POINT_SCALE * (MAX_CAPTURES - 1) + 1);
  localparam int DIV_W0      = (SUM_W > NUM_W) ? SUM_W : NUM_W;
  localparam int DIV_W       = (DIV_W0 > ACC_W) ? DIV_W0 : ACC_W;
  localparam int DIV_CNT_W   = $clog2(DIV_W + 1);
  localparam int ACC_SUM_W   = DIV_W + 2;

  localparam logic [ACC_W-1:0] ACC_MAX = '1;

  // Command queue between the front and back halves.
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

  // Result buffer depth.
  localparam int RESQ_DEPTH = 2;
  localparam int RESQ_AW    = $clog2(RESQ_DEPTH);

  // Input function codes.
  localparam logic [FUNC_W-1:0] FUNC_START  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PERIOD = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LEAD_IN      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_COUNT = 2'd2;

  typedef enum logic [1:0] {
    OP_START,
    OP_TICK,
    OP_PERIOD,
    OP_NONE
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LEAD,
    PH_WINDOW
  } phase_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_POINT,
    BS_CLOSE,
    BS_READ
  } bstate_t;

  typedef struct packed {
    op_t                 op;
    logic [PERIOD_W-1:0] period;
  } cmd_t;

  typedef struct packed {
    logic [TICK_W-1:0]   lead_in_ticks;
    logic [TICK_W-1:0]   window_ticks;
    logic [WCOUNT_W-1:0] window_count;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic                 busy_res;
    logic                 led_on;
    logic [READING_W-1:0] reading;
    logic                 reading_ready;
  } res_t;

endpackage

/* design/pfs_front.sv */
// Input side: decodes each item into a command and queues it for the sequencer.
module pfs_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [pfs_pkg::FUNC_W-1:0]    in_func,
  input  logic [pfs_pkg::PERIOD_W-1:0]  in_period,
  output logic                          cmd_valid,
  output pfs_pkg::cmd_t                 cmd,
  input  logic                          cmd_pop
);

  pfs_pkg::cmd_t                      mem_r [pfs_pkg::CMDQ_DEPTH];
  logic [pfs_pkg::CMDQ_AW-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [pfs_pkg::CMDQ_AW-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [pfs_pkg::CMDQ_AW:0]          count_r, count_nxt;
  pfs_pkg::cmd_t                      new_cmd;
  logic                               do_push;
  logic                               do_pop;

  // Code 3 has no meaning; it still yields a result, so it is queued as a no-op.
  always_comb begin
    new_cmd.period = in_period;
    unique case (in_func)
      pfs_pkg::FUNC_START:  new_cmd.op = pfs_pkg::OP_START;
      pfs_pkg::FUNC_TICK:   new_cmd.op = pfs_pkg::OP_TICK;
      pfs_pkg::FUNC_PERIOD: new_cmd.op = pfs_pkg::OP_PERIOD;
      default:              new_cmd.op = pfs_pkg::OP_NONE;
    endcase
  end

  assign in_full   = (count_r == (pfs_pkg::CMDQ_AW + 1)'(pfs_pkg::CMDQ_DEPTH));
  assign cmd_valid = (count_r != '0);
  assign cmd       = mem_r[rd_ptr_r];
  assign do_push   = in_push && !in_full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (pfs_pkg::CMDQ_AW + 1)'(do_push)
                         - (pfs_pkg::CMDQ_AW + 1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

/* design/pfs_div.sv */
// Restoring divider: one quotient bit per cycle, shared by the point and reading math.
module pfs_div (
  input  logic              clk,
  input  logic              rst_n,
  input  pfs_pkg::div_req_t req,
  output pfs_pkg::div_rsp_t rsp
);

  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [pfs_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [pfs_pkg::DIV_W-1:0]       rem_r, rem_nxt;
  logic [pfs_pkg::DIV_W-1:0]       quo_r, quo_nxt;
  logic [pfs_pkg::DIV_W-1:0]       den_r, den_nxt;
  logic [pfs_pkg::DIV_W:0]         rem_shift;
  logic [pfs_pkg::DIV_W:0]         diff;
  logic                            load;

  assign load      = req.start && !busy_r;
  assign rem_shift = {rem_r, quo_r[pfs_pkg::DIV_W-1]};
  assign diff      = rem_shift - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (load) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.num;
      den_nxt  = req.den;
    end else if (busy_r) begin
      // A negative trial difference means the divisor did not fit this step.
      rem_nxt = diff[pfs_pkg::DIV_W] ? rem_shift[pfs_pkg::DIV_W-1:0]
                                     : diff[pfs_pkg::DIV_W-1:0];
      quo_nxt = {quo_r[pfs_pkg::DIV_W-2:0], ~diff[pfs_pkg::DIV_W]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == pfs_pkg::DIV_CNT_W'(pfs_pkg::DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

/* design/pfs_back.sv */
// Sequencer core: executes queued commands, runs the window math and buffers results.
module pfs_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pfs_pkg::cfg_t        cfg,
  input  logic                 cmd_valid,
  input  pfs_pkg::cmd_t        cmd,
  output logic                 cmd_pop,
  output pfs_pkg::div_req_t    div_req,
  input  pfs_pkg::div_rsp_t    div_rsp,
  output logic                 out_empty,
  input  logic                 out_pop,
  output pfs_pkg::res_t        res
);

  pfs_pkg::bstate_t                   state_r, state_nxt;
  pfs_pkg::phase_t                    phase_r, phase_nxt;
  logic [pfs_pkg::TICK_W-1:0]         timer_r, timer_nxt;
  logic [pfs_pkg::WCOUNT_W-1:0]       wdone_r, wdone_nxt;
  logic [pfs_pkg::CAP_W-1:0]          cap_r, cap_nxt;
  logic                               armed_r, armed_nxt;
  logic [pfs_pkg::SUM_W-1:0]          sum_r, sum_nxt;
  logic [pfs_pkg::ACC_W-1:0]          acc_r, acc_nxt;
  logic [pfs_pkg::POINT_W-1:0]        pts_r, pts_nxt;
  logic [pfs_pkg::READING_W-1:0]      reading_r, reading_nxt;
  logic                               led_r, led_nxt;

  pfs_pkg::res_t                      resq_r [pfs_pkg::RESQ_DEPTH];
  logic [pfs_pkg::RESQ_AW-1:0]        rq_wr_r, rq_rd_r;
  logic [pfs_pkg::RESQ_AW:0]          rq_cnt_r;
  logic                               rq_full;
  logic                               rq_pop;

  logic                               take;
  logic                               is_close;
  logic                               close_div;
  logic                               window_last;
  logic                               read_div;
  logic [pfs_pkg::WCOUNT_W-1:0]       wdone_inc;
  logic [pfs_pkg::ACC_SUM_W-1:0]      acc_sum;
  logic                               emit;
  logic                               ready;
  pfs_pkg::res_t                      new_res;

  // Decisions shared by the state and datapath logic.
  assign rq_full     = (rq_cnt_r == (pfs_pkg::RESQ_AW + 1)'(pfs_pkg::RESQ_DEPTH));
  assign take        = (state_r == pfs_pkg::BS_IDLE) && cmd_valid && !rq_full;
  assign is_close    = take && (cmd.op == pfs_pkg::OP_TICK)
                       && (phase_r == pfs_pkg::PH_WINDOW)
                       && (timer_r <= pfs_pkg::TICK_W'(1));
  assign close_div   = is_close && (cap_r >= pfs_pkg::CAP_W'(2)) && (sum_r != '0);
  assign wdone_inc   = wdone_r + 1'b1;
  assign window_last = (wdone_inc >= cfg.window_count);
  assign read_div    = (state_r == pfs_pkg::BS_CLOSE) && window_last && (pts_r != '0);
  assign acc_sum     = pfs_pkg::ACC_SUM_W'(acc_r)
                     + pfs_pkg::ACC_SUM_W'(pfs_pkg::POINT_BIAS)
                     + pfs_pkg::ACC_SUM_W'(div_rsp.quo);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pfs_pkg::BS_IDLE: begin
        if (is_close) begin
          state_nxt = close_div ? pfs_pkg::BS_POINT : pfs_pkg::BS_CLOSE;
        end
      end
      pfs_pkg::BS_POINT: begin
        if (div_rsp.done) begin
          state_nxt = pfs_pkg::BS_CLOSE;
        end
      end
      pfs_pkg::BS_CLOSE: begin
        state_nxt = read_div ? pfs_pkg::BS_READ : pfs_pkg::BS_IDLE;
      end
      pfs_pkg::BS_READ: begin
        if (div_rsp.done) begin
          state_nxt = pfs_pkg::BS_IDLE;
        end
      end
      default: state_nxt = pfs_pkg::BS_IDLE;
    endcase
  end

  always_comb begin
    phase_nxt   = phase_r;
    timer_nxt   = timer_r;
    wdone_nxt   = wdone_r;
    cap_nxt     = cap_r;
    armed_nxt   = armed_r;
    sum_nxt     = sum_r;
    acc_nxt     = acc_r;
    pts_nxt     = pts_r;
    reading_nxt = reading_r;
    led_nxt     = led_r;
    cmd_pop     = take;
    emit        = 1'b0;
    ready       = 1'b0;
    div_req     = '0;

    unique case (state_r)
      pfs_pkg::BS_IDLE: begin
        if (take) begin
          emit = !is_close;
          case (cmd.op)
            pfs_pkg::OP_START: begin
              if (phase_r == pfs_pkg::PH_IDLE) begin
                wdone_nxt = '0;
                acc_nxt   = '0;
                pts_nxt   = '0;
                cap_nxt   = '0;
                armed_nxt = 1'b0;
                sum_nxt   = '0;
                led_nxt   = 1'b1;
                timer_nxt = cfg.lead_in_ticks;
                phase_nxt = pfs_pkg::PH_LEAD;
              end
            end
            pfs_pkg::OP_TICK: begin
              if (phase_r != pfs_pkg::PH_IDLE) begin
                if (timer_r > pfs_pkg::TICK_W'(1)) begin
                  timer_nxt = timer_r - 1'b1;
                end else if (phase_r == pfs_pkg::PH_LEAD) begin
                  timer_nxt = cfg.window_ticks;
                  cap_nxt   = '0;
                  sum_nxt   = '0;
                  armed_nxt = 1'b1;
                  phase_nxt = pfs_pkg::PH_WINDOW;
                end else begin
                  // Window end: latch the operands, then clear the window.
                  timer_nxt = '0;
                  armed_nxt = 1'b0;
                  cap_nxt   = '0;
                  sum_nxt   = '0;
                  if (close_div) begin
                    div_req.start = 1'b1;
                    div_req.num   = pfs_pkg::DIV_W'(pfs_pkg::POINT_SCALE)
                                  * pfs_pkg::DIV_W'(cap_r - 1'b1);
                    div_req.den   = pfs_pkg::DIV_W'(sum_r);
                  end else if (cap_r >= pfs_pkg::CAP_W'(2)) begin
                    // Two or more captures summing to zero always saturate.
                    acc_nxt = pfs_pkg::ACC_MAX;
                    pts_nxt = pts_r + 1'b1;
                  end
                end
              end
            end
            pfs_pkg::OP_PERIOD: begin
              if ((phase_r == pfs_pkg::PH_WINDOW) && armed_r) begin
                if (cap_r != '0) begin
                  sum_nxt = sum_r + pfs_pkg::SUM_W'(cmd.period);
                end
                cap_nxt = cap_r + 1'b1;
                if (cap_nxt >= pfs_pkg::CAP_W'(pfs_pkg::MAX_CAPTURES)) begin
                  armed_nxt = 1'b0;
                end
              end
            end
            default: ;
          endcase
        end
      end
      pfs_pkg::BS_POINT: begin
        if (div_rsp.done) begin
          acc_nxt = (acc_sum > pfs_pkg::ACC_SUM_W'(pfs_pkg::ACC_MAX))
                    ? pfs_pkg::ACC_MAX : acc_sum[pfs_pkg::ACC_W-1:0];
          pts_nxt = pts_r + 1'b1;
        end
      end
      pfs_pkg::BS_CLOSE: begin
        wdone_nxt = wdone_inc;
        if (window_last) begin
          led_nxt   = 1'b0;
          phase_nxt = pfs_pkg::PH_IDLE;
          if (read_div) begin
            div_req.start = 1'b1;
            div_req.num   = pfs_pkg::DIV_W'(acc_r);
            div_req.den   = pfs_pkg::DIV_W'(pts_r);
          end else begin
            emit = 1'b1;
          end
        end else begin
          timer_nxt = cfg.window_ticks;
          cap_nxt   = '0;
          sum_nxt   = '0;
          armed_nxt = 1'b1;
          phase_nxt = pfs_pkg::PH_WINDOW;
          emit      = 1'b1;
        end
      end
      pfs_pkg::BS_READ: begin
        if (div_rsp.done) begin
          reading_nxt = div_rsp.quo[pfs_pkg::READING_W-1:0];
          ready       = 1'b1;
          emit        = 1'b1;
        end
      end
      default: ;
    endcase

    new_res.busy_res      = (phase_nxt != pfs_pkg::PH_IDLE);
    new_res.led_on        = led_nxt;
    new_res.reading       = reading_nxt;
    new_res.reading_ready = ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= pfs_pkg::BS_IDLE;
      phase_r   <= pfs_pkg::PH_IDLE;
      timer_r   <= '0;
      wdone_r   <= '0;
      cap_r     <= '0;
      armed_r   <= 1'b0;
      sum_r     <= '0;
      acc_r     <= '0;
      pts_r     <= '0;
      reading_r <= '0;
      led_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      phase_r   <= phase_nxt;
      timer_r   <= timer_nxt;
      wdone_r   <= wdone_nxt;
      cap_r     <= cap_nxt;
      armed_r   <= armed_nxt;
      sum_r     <= sum_nxt;
      acc_r     <= acc_nxt;
      pts_r     <= pts_nxt;
      reading_r <= reading_nxt;
      led_r     <= led_nxt;
    end
  end

  // Result buffer.
  assign out_empty = (rq_cnt_r == '0);
  assign rq_pop    = out_pop && !out_empty;
  assign res       = resq_r[rq_rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_wr_r  <= '0;
      rq_rd_r  <= '0;
      rq_cnt_r <= '0;
    end else begin
      if (emit) begin
        rq_wr_r <= rq_wr_r + 1'b1;
      end
      if (rq_pop) begin
        rq_rd_r <= rq_rd_r + 1'b1;
      end
      rq_cnt_r <= rq_cnt_r + (pfs_pkg::RESQ_AW + 1)'(emit)
                           - (pfs_pkg::RESQ_AW + 1)'(rq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      resq_r[rq_wr_r] <= new_res;
    end
  end

endmodule

/* design/pulsed_frequency_sensor_sequencer.sv */
// Top level of the pulsed frequency sensor sequencer: config registers and block wiring.
//
//   Channel   Direction  Handshake               Payload
//   in_       input      in_push / in_full       in_func, in_period
//   out_      output     out_pop / out_empty     out_busy_res, out_led_on, out_reading,
//                                                out_reading_ready
//   cfg_      input      cfg_we (always taken)   cfg_index, cfg_wdata
//
// An item passes the four-entry command queue and the sequencer core takes one command
// per cycle while it is idle and the result buffer has room, so starts, periods and
// ordinary ticks then run at one item per cycle. A window close with no divide writes
// its result in the cycle after the take. A close with two or more captures and a
// nonzero sum runs the shared restoring divider (24 iterations) and writes its result
// once the divider reports done; the last window may divide again for the average.
// Reset (synchronous, rst_n low) empties both queues, idles the sequencer and loads
// the configuration defaults. A stalled result side fills the two-entry result buffer
// and then the command queue, after which in_full holds off further items.
module pulsed_frequency_sensor_sequencer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [pfs_pkg::FUNC_W-1:0]      in_func,
  input  logic [pfs_pkg::PERIOD_W-1:0]    in_period,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic                            out_busy_res,
  output logic                            out_led_on,
  output logic [pfs_pkg::READING_W-1:0]   out_reading,
  output logic                            out_reading_ready,
  input  logic                            cfg_we,
  input  logic [pfs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pfs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  // Configuration registers. Writes must only arrive while the block is idle; the block
  // itself does not enforce this, and the core reads them directly without shadowing.
  pfs_pkg::cfg_t      cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lead_in_ticks <= pfs_pkg::TICK_W'(1);
      cfg_r.window_ticks  <= pfs_pkg::TICK_W'(1);
      cfg_r.window_count  <= pfs_pkg::WCOUNT_W'(9);
    end else if (cfg_we) begin
      unique case (cfg_index)
        pfs_pkg::CFG_LEAD_IN:      cfg_r.lead_in_ticks <= cfg_wdata;
        pfs_pkg::CFG_WINDOW_TICKS: cfg_r.window_ticks  <= cfg_wdata;
        pfs_pkg::CFG_WINDOW_COUNT: cfg_r.window_count  <= cfg_wdata[pfs_pkg::WCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Front half: decode and queue commands.
  logic               cmd_valid;
  logic               cmd_pop;
  pfs_pkg::cmd_t      cmd;

  pfs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_func   (in_func),
    .in_period (in_period),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // Shared divider for the window point and for the final average.
  pfs_pkg::div_req_t  div_req;
  pfs_pkg::div_rsp_t  div_rsp;

  pfs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Back half: sequencing, window math and the result buffer.
  pfs_pkg::res_t      res;

  pfs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .res       (res)
  );

  assign out_busy_res      = res.busy_res;
  assign out_led_on        = res.led_on;
  assign out_reading       = res.reading;
  assign out_reading_ready = res.reading_ready;

  // The LED is lit exactly while a measurement runs.
  a_led_tracks_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_led_on == out_busy_res))
    else $error("LED level disagrees with busy state");

  // A fresh reading only appears as the measurement ends.
  a_ready_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_reading_ready) |-> !out_busy_res)
    else $error("reading reported while still busy");

  // The core never takes a command from an empty queue.
  a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid)
    else $error("command taken from an empty queue");

  // Reset leaves both sides empty and ready.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not cleared by reset");

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the pulsed frequency sensor sequencer with a status predictor.
module testbench;
  import pfs_pkg::*;

  // The one function code the block has no use for.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // Point arithmetic, kept here so that a wrong constant in the design shows up.
  localparam int POINT_WEIGHT = 40000;
  localparam int POINT_OFFSET = 75;

  // Cycles without any transfer before the run is called hung. The slowest
  // legal gap is the settling pause plus a window close with two divides.
  localparam int QUIET_LIMIT = 2000;
  // Quiet cycles after the last status transfer, well past the divider latency.
  localparam int DRAIN_CYCLES = 64;
  // Items that change the state of the sequencer, counted before the calm final part.
  localparam int ITEM_TARGET = 1900;

  // Tracks the sequencer state item by item and owes one status per accepted item.
  class measurement_tracker;
    logic [TICK_W-1:0]    lead_in_ticks;
    logic [TICK_W-1:0]    window_ticks;
    logic [WCOUNT_W-1:0]  window_count;
    phase_t               phase;
    logic [TICK_W-1:0]    tick_timer;
    logic [WCOUNT_W-1:0]  windows_done;
    logic [CAP_W-1:0]     capture_total;
    bit                   capture_armed;
    logic [SUM_W-1:0]     period_sum;
    logic [ACC_W-1:0]     point_acc;
    logic [POINT_W-1:0]   point_total;
    logic [READING_W-1:0] reading;
    bit                   led;
    res_t                 owed[$];
    int                   errors;

    function new();
      lead_in_ticks = 1;
      window_ticks  = 1;
      window_count  = 9;
      phase         = PH_IDLE;
      tick_timer    = '0;
      windows_done  = '0;
      capture_total = '0;
      capture_armed = 0;
      period_sum    = '0;
      point_acc     = '0;
      point_total   = '0;
      reading       = '0;
      led           = 0;
      errors        = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_LEAD_IN:      lead_in_ticks = value;
        CFG_WINDOW_TICKS: window_ticks = value;
        CFG_WINDOW_COUNT: window_count = value[WCOUNT_W-1:0];
        default: ;
      endcase
    endfunction

    function void open_window();
      tick_timer    = window_ticks;
      capture_total = '0;
      period_sum    = '0;
      capture_armed = 1;
      phase         = PH_WINDOW;
    endfunction

    // A window with two or more captures adds one saturating point; the first
    // capture only marks the start of the first period and is not summed.
    function void close_window();
      longint unsigned q;
      longint unsigned total;
      capture_armed = 0;
      if (capture_total >= 2) begin
        if (period_sum == 0) begin
          q = 64'hFFFF;
        end else begin
          q = (64'(POINT_WEIGHT) * 64'(capture_total - 1)) / 64'(period_sum);
        end
        total = 64'(point_acc) + 64'(POINT_OFFSET) + q;
        point_acc = (total > 64'hFFFF) ? 16'hFFFF : total[ACC_W-1:0];
        point_total = point_total + 1'b1;
      end
      capture_total = '0;
      period_sum    = '0;
    endfunction

    // Applies one accepted item and queues the status it must produce.
    // Returns 1 when the item changed the state, 0 when the block ignores it.
    function bit note_item(logic [FUNC_W-1:0] func, logic [PERIOD_W-1:0] period);
      bit   acted;
      res_t want;
      acted = 0;
      want.reading_ready = 1'b0;
      case (func)
        FUNC_START: begin
          if (phase == PH_IDLE) begin
            acted         = 1;
            windows_done  = '0;
            point_acc     = '0;
            point_total   = '0;
            capture_total = '0;
            capture_armed = 0;
            period_sum    = '0;
            led           = 1;
            tick_timer    = lead_in_ticks;
            phase         = PH_LEAD;
          end
        end
        FUNC_TICK: begin
          if (phase != PH_IDLE) begin
            acted = 1;
            if (tick_timer > 1) begin
              tick_timer = tick_timer - 1'b1;
            end else begin
              tick_timer = '0;
              if (phase == PH_LEAD) begin
                open_window();
              end else begin
                close_window();
                windows_done = windows_done + 1'b1;
                if (windows_done >= window_count) begin
                  led = 0;
                  if (point_total > 0) begin
                    reading = point_acc / point_total;
                    want.reading_ready = 1'b1;
                  end
                  phase = PH_IDLE;
                end else begin
                  open_window();
                end
              end
            end
          end
        end
        FUNC_PERIOD: begin
          if (phase == PH_WINDOW && capture_armed) begin
            acted = 1;
            if (capture_total > 0) period_sum = period_sum + period;
            capture_total = capture_total + 1'b1;
            if (capture_total >= MAX_CAPTURES) capture_armed = 0;
          end
        end
        default: ;
      endcase
      want.busy_res = (phase != PH_IDLE);
      want.led_on   = led;
      want.reading  = reading;
      owed.push_back(want);
      return acted;
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    // Compares one status transfer with the oldest status still owed.
    function void check_status(res_t got);
      res_t want;
      if (owed.size() == 0) begin
        $display("%0t: status with no item waiting, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = owed.pop_front();
      compare_field("busy_res", 16'(want.busy_res), 16'(got.busy_res));
      compare_field("led_on", 16'(want.led_on), 16'(got.led_on));
      compare_field("reading", want.reading, got.reading);
      compare_field("reading_ready", 16'(want.reading_ready), 16'(got.reading_ready));
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_push;
  logic                  in_full;
  logic [FUNC_W-1:0]     in_func;
  logic [PERIOD_W-1:0]   in_period;
  logic                  out_empty;
  logic                  out_pop;
  logic                  out_busy_res;
  logic                  out_led_on;
  logic [READING_W-1:0]  out_reading;
  logic                  out_reading_ready;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  measurement_tracker tracker = new();

  // Idle behavior of the two sides, changed per measurement by the sequence below.
  int send_gap_pct;
  int pop_stall_pct;
  // Set for the last part of the run, where neither side idles.
  bit calm;
  // State-changing items sent so far.
  int live_items;
  int quiet_cycles = 0;

  pulsed_frequency_sensor_sequencer i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_func           (in_func),
    .in_period         (in_period),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_busy_res      (out_busy_res),
    .out_led_on        (out_led_on),
    .out_reading       (out_reading),
    .out_reading_ready (out_reading_ready),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Hang detection: any transfer on either side restarts the count.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // Result side. Every status transfer is checked at the edge that takes it.
  // Pop drops low in random bursts, except in the calm part.
  initial begin : result_side
    int   hold;
    res_t got;
    hold = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) begin
        got.busy_res      = out_busy_res;
        got.led_on        = out_led_on;
        got.reading       = out_reading;
        got.reading_ready = out_reading_ready;
        tracker.check_status(got);
      end
      if (hold > 0) begin
        hold--;
        out_pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < pop_stall_pct) begin
        hold = $urandom_range(0, 5);
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Periods come from a mix: zero, all ones, very short, very long and uniform.
  function automatic logic [PERIOD_W-1:0] pick_period();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return PERIOD_W'($urandom_range(0, 15));
      3:       return PERIOD_W'($urandom_range(16'hFF00, 16'hFFFF));
      default: return PERIOD_W'($urandom);
    endcase
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 5;
      2:       return 20;
      default: return 40;
    endcase
  endfunction

  // Sends one item and holds it until the block takes it. The prediction is
  // made here, at the accepting edge, so that the next choice of item sees
  // the state this item leaves behind. push stays high between back-to-back
  // items; it only drops for an idle burst.
  task automatic send_item(input logic [FUNC_W-1:0] func, input logic [PERIOD_W-1:0] period);
    if (!calm && $urandom_range(0, 99) < send_gap_pct) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_push   <= 1'b1;
    in_func   <= func;
    in_period <= period;
    @(posedge clk);
    while (in_full) @(posedge clk);
    if (tracker.note_item(func, period)) live_items++;
  endtask

  // Stops the input side until every owed status has come back, then lets the
  // block sit quiet for a while so that configuration writes meet an idle block.
  task automatic settle();
    in_push <= 1'b0;
    while (tracker.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes the registers selected by the mask on consecutive edges. The write
  // enable stays high across the burst and drops once at the end.
  task automatic write_config(input logic [TICK_W-1:0] lead, input logic [TICK_W-1:0] wlen,
                              input logic [WCOUNT_W-1:0] wcount, input logic [2:0] mask);
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] value;
    for (int i = 0; i < 3; i++) begin
      if (mask[i]) begin
        case (i)
          0: begin
            idx   = CFG_LEAD_IN;
            value = lead;
          end
          1: begin
            idx   = CFG_WINDOW_TICKS;
            value = wlen;
          end
          default: begin
            idx   = CFG_WINDOW_COUNT;
            value = CFG_DATA_W'(wcount);
          end
        endcase
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        tracker.write_reg(idx, value);
      end
    end
    cfg_we <= 1'b0;
  endtask

  // One measurement with random content. While idle, mostly starts with some
  // noise; once running, ticks and captures in the given mix, with a little noise
  // (starts while busy, periods in the lead-in, the unused code) mixed in.
  task automatic run_measurement(input int period_pct);
    while (tracker.phase == PH_IDLE) begin
      if ($urandom_range(0, 99) < 85) begin
        send_item(FUNC_START, PERIOD_W'($urandom));
      end else begin
        send_item(FUNC_W'($urandom_range(1, 3)), pick_period());
      end
    end
    while (tracker.phase != PH_IDLE) begin
      if ($urandom_range(0, 99) < 6) begin
        send_item(FUNC_W'($urandom_range(0, 3)), pick_period());
      end else if (tracker.phase == PH_WINDOW && $urandom_range(0, 99) < period_pct) begin
        send_item(FUNC_PERIOD, pick_period());
      end else begin
        send_item(FUNC_TICK, PERIOD_W'($urandom));
      end
    end
  endtask

  // A single one-tick window flooded past the capture limit; the captures
  // beyond the limit must be dropped.
  task automatic flood_window(input logic [PERIOD_W-1:0] period, input int count);
    settle();
    write_config('0, '0, 8'd1, 3'b111);
    send_item(FUNC_START, '0);
    send_item(FUNC_TICK, '0);
    repeat (count) send_item(FUNC_PERIOD, period);
    send_item(FUNC_TICK, '1);
  endtask

  initial begin
    logic [TICK_W-1:0]   lead;
    logic [TICK_W-1:0]   wlen;
    logic [WCOUNT_W-1:0] wcount;
    int                  pick;
    in_push       = 1'b0;
    in_func       = FUNC_START;
    in_period     = '0;
    out_pop       = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_LEAD_IN;
    cfg_wdata     = '0;
    rst_n         = 1'b0;
    calm          = 0;
    send_gap_pct  = 0;
    pop_stall_pct = 0;
    live_items    = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Zero lead-in and zero window length both act as one tick.
    write_config('0, '0, 8'd2, 3'b111);
    pop_stall_pct = 20;
    send_item(FUNC_TICK, '1);             // tick while idle is ignored
    send_item(FUNC_PERIOD, '1);           // period while idle is ignored
    send_item(FUNC_UNUSED, '0);           // unused code is ignored
    send_item(FUNC_START, '0);
    send_item(FUNC_START, '1);            // start while busy is ignored
    send_item(FUNC_PERIOD, '1);           // period during the lead-in is ignored
    send_item(FUNC_TICK, '0);             // lead-in ends, window one opens
    send_item(FUNC_PERIOD, '1);           // first capture, not summed
    send_item(FUNC_PERIOD, '0);
    send_item(FUNC_PERIOD, '0);           // the periods sum to zero: accumulator saturates
    send_item(FUNC_TICK, '0);             // window one closes, window two opens
    send_item(FUNC_PERIOD, 16'd1);        // a lone capture is too few for a point
    send_item(FUNC_TICK, '0);             // last window closes and a reading comes out

    // A window count of zero runs one window.
    settle();
    write_config('0, 16'd1, 8'd0, 3'b110);
    send_gap_pct = 20;
    send_item(FUNC_START, '1);
    send_item(FUNC_TICK, '1);
    send_item(FUNC_PERIOD, 16'd100);
    send_item(FUNC_PERIOD, '1);
    send_item(FUNC_PERIOD, 16'd1);
    send_item(FUNC_TICK, '1);
    // A measurement without a point keeps the old reading and raises no ready.
    send_item(FUNC_START, '0);
    send_item(FUNC_TICK, '0);
    send_item(FUNC_TICK, '0);

    // Full windows: the longest periods give the largest sum, the shortest
    // give the largest point.
    flood_window('1, MAX_CAPTURES + 2);
    flood_window(16'd1, MAX_CAPTURES + 1);

    // The largest window count, with short windows.
    settle();
    write_config(16'd1, '0, 8'd255, 3'b111);
    send_gap_pct  = 10;
    pop_stall_pct = 10;
    run_measurement(60);

    // Random measurements. Some follow each other with no pause and no new
    // configuration, so that a start right after the end is exercised too.
    while (live_items < ITEM_TARGET) begin
      if ($urandom_range(0, 99) < 60) begin
        settle();
        lead = ($urandom_range(0, 9) == 0) ? TICK_W'($urandom_range(4, 20))
                                           : TICK_W'($urandom_range(0, 3));
        wlen = ($urandom_range(0, 9) == 0) ? TICK_W'($urandom_range(4, 20))
                                           : TICK_W'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          wcount = '0;
        end else if (pick < 85) begin
          wcount = WCOUNT_W'($urandom_range(1, 5));
        end else begin
          wcount = WCOUNT_W'($urandom_range(6, 12));
        end
        write_config(lead, wlen, wcount, 3'($urandom_range(1, 7)));
      end
      send_gap_pct  = pick_idle_pct();
      pop_stall_pct = pick_idle_pct();
      run_measurement(40 + 15 * $urandom_range(0, 3));
    end

    // Calm final part: a longer lead-in and window, back to back without idling.
    calm = 1;
    settle();
    write_config(16'd40, 16'd40, 8'd1, 3'b111);
    send_item(FUNC_START, '0);
    while (tracker.phase == PH_LEAD) send_item(FUNC_TICK, PERIOD_W'($urandom));
    repeat (3) send_item(FUNC_PERIOD, pick_period());
    while (tracker.phase != PH_IDLE) send_item(FUNC_TICK, PERIOD_W'($urandom));

    in_push <= 1'b0;
    while (tracker.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
